[rtl/core/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define SFV_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define SFV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/sfv_pkg.sv]
`timescale 1ns / 1ps

package sfv_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE   = 2'd1;

  localparam logic [7:0] START_BYTE_RESET = 8'h02;
  localparam logic [7:0] END_BYTE_RESET   = 8'h03;

  localparam logic [7:0] MIN_FRAME_LEN = 8'd8;
  localparam logic [7:0] SUM_START_IDX = 8'd4;
  localparam logic [7:0] LEN_IDX       = 8'd1;

  localparam logic [7:0] HEX_DIGIT_MAX = 8'h39;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'h37;
  localparam logic [7:0] HEX_DIGIT_OFS = 8'h30;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_frame;
  } sfv_item_t;

  typedef struct packed {
    logic       frame_valid;
    logic [7:0] frame_length;
  } sfv_result_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
  } sfv_cfg_t;

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = (c > HEX_DIGIT_MAX) ? (c - HEX_ALPHA_OFS) : (c - HEX_DIGIT_OFS);
    return v[3:0];
  endfunction

endpackage

[rtl/core/sfv_cfg_regs.sv]
`timescale 1ns / 1ps

module sfv_cfg_regs
  import sfv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [7:0]           wr_data,
  output sfv_cfg_t             cfg
);

  sfv_cfg_t cfg_r;
  sfv_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_START_BYTE: cfg_nxt.start_byte = wr_data;
        CFG_END_BYTE:   cfg_nxt.end_byte   = wr_data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte <= START_BYTE_RESET;
      cfg_r.end_byte   <= END_BYTE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/core/sfv_in_stage.sv]
`timescale 1ns / 1ps

module sfv_in_stage
  import sfv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  sfv_item_t in_item,
  input  logic      consume,
  output logic      item_valid,
  output sfv_item_t item
);

  logic      valid_r;
  logic      valid_nxt;
  sfv_item_t item_r;
  logic      load;

  assign in_ready  = rst_n && (!valid_r || consume);
  assign load      = in_valid && in_ready;
  assign valid_nxt = load ? 1'b1 : (consume ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

[rtl/core/sfv_frame_check.sv]
`timescale 1ns / 1ps

module sfv_frame_check
  import sfv_pkg::*;
#(
  parameter int MAX_FRAME_LEN = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  sfv_cfg_t    cfg,
  input  logic        item_valid,
  input  sfv_item_t   item,
  input  logic        out_free,
  output logic        consume,
  output logic        result_load,
  output sfv_result_t result
);

  localparam logic [7:0] MaxLen = 8'(MAX_FRAME_LEN);

  logic [7:0] byte_count_r, byte_count_nxt;
  logic [7:0] running_sum_r, running_sum_nxt;
  logic [7:0] recent_r [3];
  logic [7:0] recent_nxt [3];
  logic [7:0] length_byte_r, length_byte_nxt;
  logic       start_matched_r, start_matched_nxt;

  logic [7:0] sum_upd;
  logic [7:0] count_upd;
  logic [7:0] length_upd;
  logic       start_upd;
  logic [7:0] hex_sum;
  logic       frame_ok;

  assign consume     = item_valid && (!item.end_of_frame || out_free);
  assign result_load = consume && item.end_of_frame;

  always_comb begin
    sum_upd    = (byte_count_r >= SUM_START_IDX) ? (running_sum_r + recent_r[2])
                                                 : running_sum_r;
    count_upd  = (byte_count_r < MaxLen) ? (byte_count_r + 8'd1) : byte_count_r;
    start_upd  = (byte_count_r == 8'd0) ? (item.rx_byte == cfg.start_byte)
                                        : start_matched_r;
    length_upd = (byte_count_r == LEN_IDX) ? item.rx_byte : length_byte_r;
    hex_sum    = {hex_nibble(recent_r[1]), hex_nibble(recent_r[0])};
    frame_ok   = (count_upd >= MIN_FRAME_LEN) && (count_upd < MaxLen) && start_upd &&
                 (item.rx_byte == cfg.end_byte) && (length_upd == count_upd) &&
                 (hex_sum == sum_upd);
  end

  assign result.frame_valid  = frame_ok;
  assign result.frame_length = count_upd;

  always_comb begin
    byte_count_nxt    = byte_count_r;
    running_sum_nxt   = running_sum_r;
    length_byte_nxt   = length_byte_r;
    start_matched_nxt = start_matched_r;
    recent_nxt        = recent_r;
    if (consume) begin
      if (item.end_of_frame) begin
        byte_count_nxt    = 8'd0;
        running_sum_nxt   = 8'd0;
        length_byte_nxt   = 8'd0;
        start_matched_nxt = 1'b0;
        recent_nxt[0]     = 8'd0;
        recent_nxt[1]     = 8'd0;
        recent_nxt[2]     = 8'd0;
      end else begin
        byte_count_nxt    = count_upd;
        running_sum_nxt   = sum_upd;
        length_byte_nxt   = length_upd;
        start_matched_nxt = start_upd;
        recent_nxt[0]     = item.rx_byte;
        recent_nxt[1]     = recent_r[0];
        recent_nxt[2]     = recent_r[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r    <= 8'd0;
      running_sum_r   <= 8'd0;
      length_byte_r   <= 8'd0;
      start_matched_r <= 1'b0;
      recent_r[0]     <= 8'd0;
      recent_r[1]     <= 8'd0;
      recent_r[2]     <= 8'd0;
    end else begin
      byte_count_r    <= byte_count_nxt;
      running_sum_r   <= running_sum_nxt;
      length_byte_r   <= length_byte_nxt;
      start_matched_r <= start_matched_nxt;
      recent_r        <= recent_nxt;
    end
  end

endmodule

[rtl/core/serial_frame_validator_core.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Word
// in_       input      in_valid/in_ready  in_rx_byte, in_end_of_frame
// out_      output     out_valid/out_ready out_frame_valid, out_frame_length
// cfg_      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One word is taken per cycle unless a final word stalls. A word passes the input register and
// then, if final, its result passes the result register; the per-word sum and compares sit
// between them. A full result register stalls only a final word; other words
// keep flowing. Reset is synchronous and clears all frame state and both valid flags;
// ready is low while reset is held.

module serial_frame_validator_core
  import sfv_pkg::*;
#(
  parameter int MAX_FRAME_LEN = 255
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  input  logic                 in_end_of_frame,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_frame_valid,
  output logic [7:0]           out_frame_length,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  sfv_cfg_t    cfg;
  sfv_item_t   in_item;
  sfv_item_t   item;
  logic        item_valid;
  logic        consume;
  logic        result_load;
  sfv_result_t result;

  logic        out_valid_r, out_valid_nxt;
  sfv_result_t result_r;

  assign cfg_ready = rst_n;

  sfv_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign in_item.rx_byte      = in_rx_byte;
  assign in_item.end_of_frame = in_end_of_frame;

  sfv_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .consume    (consume),
    .item_valid (item_valid),
    .item       (item)
  );

  sfv_frame_check #(
    .MAX_FRAME_LEN (MAX_FRAME_LEN)
  ) u_frame_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .item_valid  (item_valid),
    .item        (item),
    .out_free    (!out_valid_r || out_ready),
    .consume     (consume),
    .result_load (result_load),
    .result      (result)
  );

  assign out_valid_nxt = result_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result_r <= result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_valid  = result_r.frame_valid;
  assign out_frame_length = result_r.frame_length;

endmodule

[rtl/core/sfv_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfv_checker
  import sfv_pkg::*;
#(
  parameter int MAX_FRAME_LEN = 255
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_end_of_frame,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_frame_valid,
  input logic [7:0] out_frame_length
);

  localparam logic [7:0] MaxLen = 8'(MAX_FRAME_LEN);

  `SFV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `SFV_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_frame_valid) && $stable(out_frame_length))
  `SFV_ASSERT_SAME(a_rose_after_final, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready && in_end_of_frame, 2))
  `SFV_ASSERT_SAME(a_valid_length, clk, rst_n, out_valid && out_frame_valid, (out_frame_length >= MIN_FRAME_LEN) && (out_frame_length < MaxLen))

endmodule

bind serial_frame_validator_core sfv_checker #(
  .MAX_FRAME_LEN (MAX_FRAME_LEN)
) u_sfv_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_end_of_frame  (in_end_of_frame),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_frame_valid  (out_frame_valid),
  .out_frame_length (out_frame_length)
);
